[sv/bmx_pkg.sv]
// Shared types and constants for the binary trie maximum-xor block.
package bmx_pkg;

    // Fixed field widths of the stream words
    localparam int KIND_W   = 2;
    localparam int KEY_W    = 31;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 20;

    // Defaults for the top-level parameters
    localparam int DEF_VALUE_BITS = 31;
    localparam int DEF_NODE_POOL  = 65536;

    // Depth of the queue between the front and the engine
    localparam int QUEUE_DEPTH = 2;

    // Saturation point of a node count
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Codes of the kind field on the input word
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

    // Decoded operation carried through the queue
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_ABSENT = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // Engine sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_FIT,
        S_UPD,
        S_QROOT,
        S_QUERY,
        S_DONE
    } t_state;

endpackage

[sv/bmx_front.sv]
// Input stage: takes stream words, decodes the kind and sizes the value.
module bmx_front import bmx_pkg::*; #(
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic [KEY_W-1:0]      i_key,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_op                   o_op,
    output logic [VALUE_BITS-1:0] o_value
);

    logic                  r_valid;
    t_op                   r_op;
    logic [VALUE_BITS-1:0] r_value;
    t_op                   n_op;
    logic [VALUE_BITS-1:0] n_value;

    // Decode the kind into an operation
    always_comb begin
        case (i_kind)
            KIND_INSERT: n_op = OP_INSERT;
            KIND_DELETE: n_op = OP_DELETE;
            KIND_QUERY:  n_op = OP_QUERY;
            default:     n_op = OP_NONE;
        endcase
    end

    // Fit the key to the trie width: drop or zero-fill the upper bits
    for (genvar g = 0; g < VALUE_BITS; g++) begin : g_val
        if (g < KEY_W) begin : g_in
            assign n_value[g] = i_key[g];
        end else begin : g_zero
            assign n_value[g] = 1'b0;
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_op    = r_op;
    assign o_value = r_value;

    // Hold one decoded word until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Capture the payload on accept
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_op    <= n_op;
            r_value <= n_value;
        end
    end

endmodule

[sv/bmx_fifo.sv]
// Short queue that decouples the input stage from the trie engine.
module bmx_fifo import bmx_pkg::*; #(
    parameter int WIDTH = DEF_VALUE_BITS + 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);

    logic [WIDTH-1:0] r_slot [QUEUE_DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;
    logic             push;
    logic             pop;

    assign o_ready = (r_cnt != FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_slot[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == LAST_SLOT) ? '0 : r_wp + PW'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == LAST_SLOT) ? '0 : r_rp + PW'(1);
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Store the incoming word
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= i_data;
        end
    end

endmodule

[sv/bmx_engine.sv]
// Trie engine: node store, level-by-level walk sequencer and result register.
module bmx_engine import bmx_pkg::*; #(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int NODE_POOL  = DEF_NODE_POOL
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_op                   i_op,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [KEY_W-1:0]      o_max_xor,
    output t_status               o_status
);

    localparam int IW = $clog2(NODE_POOL);
    localparam int DW = $clog2(VALUE_BITS + 1);
    localparam int EW = 2 * IW + COUNT_W;
    localparam logic [IW-1:0] ROOT_NODE = IW'(1);
    localparam logic [IW-1:0] LAST_NODE = IW'(NODE_POOL - 1);
    localparam logic [DW-1:0] TOP_DEPTH = DW'(VALUE_BITS);

    // Node store: {child_one, child_zero, count} per entry
    logic [EW-1:0]         r_mem [NODE_POOL];
    logic [EW-1:0]         r_qa;
    logic [EW-1:0]         r_qb;
    logic                  r_live_a;
    logic                  r_live_b;

    // Sequencer and walk registers
    t_state                r_state;
    t_state                n_state;
    t_op                   r_op;
    logic [VALUE_BITS-1:0] r_val;
    logic [VALUE_BITS-1:0] r_walk;
    logic [VALUE_BITS-1:0] r_path;
    logic [VALUE_BITS-1:0] n_path;
    logic [DW-1:0]         r_d;
    logic [DW-1:0]         r_miss;
    logic [IW-1:0]         r_node;
    logic [IW-1:0]         r_next_free;
    logic                  r_root_live;
    logic [VALUE_BITS-1:0] r_res_xor;
    t_status               r_res_st;
    logic                  r_out_valid;
    logic [KEY_W-1:0]      r_out_xor;
    t_status               r_out_st;

    // Decoded entries and walk decisions
    logic [EW-1:0]         ent_a;
    logic [EW-1:0]         ent_b;
    logic [COUNT_W-1:0]    a_cnt;
    logic [IW-1:0]         a_c0;
    logic [IW-1:0]         a_c1;
    logic                  walk_bit;
    logic [IW-1:0]         walk_child;
    logic [EW-1:0]         opp_ent;
    logic [EW-1:0]         same_ent;
    logic [EW-1:0]         sel_ent;
    logic                  take_opp;
    logic [IW-1:0]         new_node;
    logic                  alloc;
    logic [COUNT_W-1:0]    upd_cnt;
    logic [IW-1:0]         upd_c0;
    logic [IW-1:0]         upd_c1;
    logic [IW-1:0]         upd_next;
    logic [IW:0]           fit_sum;
    logic                  no_fit;
    logic [KEY_W-1:0]      res_key;
    logic                  live_a;
    logic                  live_b;

    // Sequencer outputs
    logic                  pop;
    logic                  rd_a;
    logic [IW-1:0]         ra;
    logic                  rd_b;
    logic [IW-1:0]         rb;
    logic                  we;
    logic [EW-1:0]         wd;
    logic                  fin;
    t_status               fin_st;
    logic [VALUE_BITS-1:0] fin_xor;
    logic                  to_fit;
    logic                  restart;
    logic                  descend;
    logic                  alloc_go;
    logic                  load_out;

    // Entries that were never allocated read as empty
    assign ent_a = r_live_a ? r_qa : '0;
    assign ent_b = r_live_b ? r_qb : '0;
    assign a_cnt = ent_a[COUNT_W-1:0];
    assign a_c0  = ent_a[COUNT_W +: IW];
    assign a_c1  = ent_a[COUNT_W+IW +: IW];

    // Follow the value's bit at the current level
    assign walk_bit   = r_walk[VALUE_BITS-1];
    assign walk_child = walk_bit ? a_c1 : a_c0;

    // Query: prefer the child on the opposite bit when it holds values
    assign opp_ent  = walk_bit ? ent_a : ent_b;
    assign same_ent = walk_bit ? ent_b : ent_a;
    assign take_opp = (opp_ent[COUNT_W-1:0] != '0);
    assign sel_ent  = take_opp ? opp_ent : same_ent;
    assign n_path   = (r_path << 1) | VALUE_BITS'(take_opp);

    // Update pass: bump the count, hang a fresh node where the path breaks
    assign new_node = r_next_free + IW'(1);
    assign alloc    = (r_op == OP_INSERT) && (r_d != '0) && (walk_child == '0);
    assign upd_cnt  = (r_op == OP_INSERT) ? a_cnt + COUNT_W'(1) : a_cnt - COUNT_W'(1);
    assign upd_c0   = (alloc && !walk_bit) ? new_node : a_c0;
    assign upd_c1   = (alloc && walk_bit) ? new_node : a_c1;
    assign upd_next = alloc ? new_node : walk_child;
    assign wd       = {upd_c1, upd_c0, upd_cnt};

    // Pool check for the nodes an insert still needs
    assign fit_sum = {1'b0, r_next_free} + (IW + 1)'(r_miss);
    assign no_fit  = (r_next_free >= LAST_NODE) || (fit_sum > {1'b0, LAST_NODE});

    // An address holds data only once it has been allocated and written
    assign live_a = (ra != '0) && (ra <= r_next_free) && ((ra != ROOT_NODE) || r_root_live);
    assign live_b = (rb != '0) && (rb <= r_next_free) && ((rb != ROOT_NODE) || r_root_live);

    // Fit the result to the output field
    for (genvar g = 0; g < KEY_W; g++) begin : g_res
        if (g < VALUE_BITS) begin : g_in
            assign res_key[g] = r_res_xor[g];
        end else begin : g_zero
            assign res_key[g] = 1'b0;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_op == OP_QUERY) begin
                        n_state = S_QROOT;
                    end else if (i_op != OP_NONE) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (to_fit) begin
                    n_state = S_FIT;
                end
            end
            S_FIT:   n_state = S_UPD;
            S_UPD:   n_state = S_UPD;
            S_QROOT: n_state = S_QUERY;
            S_QUERY: n_state = S_QUERY;
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (fin) begin
            n_state = S_DONE;
        end
    end

    // Sequencer outputs: memory ports, walk steps, finish
    always_comb begin
        pop      = 1'b0;
        rd_a     = 1'b0;
        ra       = ROOT_NODE;
        rd_b     = 1'b0;
        rb       = '0;
        we       = 1'b0;
        fin      = 1'b0;
        fin_st   = ST_OK;
        fin_xor  = '0;
        to_fit   = 1'b0;
        restart  = 1'b0;
        descend  = 1'b0;
        alloc_go = 1'b0;
        load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                pop = i_valid;
                if (i_valid) begin
                    if (i_op == OP_NONE) begin
                        fin = 1'b1;
                    end else begin
                        rd_a = 1'b1;
                    end
                end
            end
            S_CHECK: begin
                if (r_op == OP_INSERT) begin
                    if ((r_d == TOP_DEPTH) && (a_cnt == COUNT_MAX)) begin
                        fin    = 1'b1;
                        fin_st = ST_FULL;
                    end else if ((r_d == '0) || (walk_child == '0)) begin
                        to_fit = 1'b1;
                    end else begin
                        rd_a    = 1'b1;
                        ra      = walk_child;
                        descend = 1'b1;
                    end
                end else begin
                    if (a_cnt == '0) begin
                        fin    = 1'b1;
                        fin_st = ST_ABSENT;
                    end else if (r_d == '0) begin
                        to_fit = 1'b1;
                    end else if (walk_child == '0) begin
                        fin    = 1'b1;
                        fin_st = ST_ABSENT;
                    end else begin
                        rd_a    = 1'b1;
                        ra      = walk_child;
                        descend = 1'b1;
                    end
                end
            end
            S_FIT: begin
                if ((r_op == OP_INSERT) && no_fit) begin
                    fin    = 1'b1;
                    fin_st = ST_FULL;
                end else begin
                    rd_a    = 1'b1;
                    restart = 1'b1;
                end
            end
            S_UPD: begin
                we = 1'b1;
                if (r_d == '0) begin
                    fin = 1'b1;
                end else begin
                    rd_a     = 1'b1;
                    ra       = upd_next;
                    descend  = 1'b1;
                    alloc_go = alloc;
                end
            end
            S_QROOT: begin
                if (a_cnt == '0) begin
                    fin    = 1'b1;
                    fin_st = ST_EMPTY;
                end else begin
                    rd_a = 1'b1;
                    ra   = a_c0;
                    rd_b = 1'b1;
                    rb   = a_c1;
                end
            end
            S_QUERY: begin
                descend = 1'b1;
                if (r_d == DW'(1)) begin
                    fin     = 1'b1;
                    fin_xor = n_path;
                end else begin
                    rd_a = 1'b1;
                    ra   = sel_ent[COUNT_W +: IW];
                    rd_b = 1'b1;
                    rb   = sel_ent[COUNT_W+IW +: IW];
                end
            end
            S_DONE: begin
                load_out = !r_out_valid || i_ready;
            end
            default: begin
                fin = 1'b0;
            end
        endcase
    end

    assign o_ready   = (r_state == S_IDLE);
    assign o_valid   = r_out_valid;
    assign o_max_xor = r_out_xor;
    assign o_status  = r_out_st;

    // Node store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[r_node] <= wd;
        end
        if (rd_a) begin
            r_qa <= r_mem[ra];
        end
        if (rd_b) begin
            r_qb <= r_mem[rb];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_next_free <= ROOT_NODE;
            r_root_live <= 1'b0;
            r_out_valid <= 1'b0;
            r_live_a    <= 1'b0;
            r_live_b    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (alloc_go) begin
                r_next_free <= new_node;
            end
            if (we && (r_node == ROOT_NODE)) begin
                r_root_live <= 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (rd_a) begin
                r_live_a <= live_a;
            end
            if (rd_b) begin
                r_live_b <= live_b;
            end
        end
    end

    // Walk datapath
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_op   <= i_op;
            r_val  <= i_value;
            r_walk <= i_value;
            r_d    <= TOP_DEPTH;
            r_node <= ROOT_NODE;
        end
        if (restart) begin
            r_walk <= r_val;
            r_d    <= TOP_DEPTH;
            r_node <= ROOT_NODE;
        end
        if (descend) begin
            r_walk <= r_walk << 1;
            r_d    <= r_d - DW'(1);
            r_node <= ra;
        end
        if (to_fit) begin
            r_miss <= r_d;
        end
        if (r_state == S_QUERY) begin
            r_path <= n_path;
        end
        if (fin) begin
            r_res_xor <= fin_xor;
            r_res_st  <= fin_st;
        end
        if (load_out) begin
            r_out_xor <= res_key;
            r_out_st  <= r_res_st;
        end
    end

    // Allocation never runs past the pool
    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free <= LAST_NODE)
        else $error("node allocation ran past the pool");

    // Writes land only on allocated nodes, never on the null node
    a_write_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (r_node != '0) && (r_node <= r_next_free))
        else $error("write to an unallocated node");

    // The allocation pointer only ever steps by one
    a_bump_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_next_free != $past(r_next_free)))
        |-> (r_next_free == $past(r_next_free) + IW'(1)))
        else $error("allocation pointer jumped");

    // A failed item carries a zero result
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_st != ST_OK)) |-> (r_out_xor == '0))
        else $error("nonzero result on a failed item");

    // An accepted item always leaves the idle state
    a_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> (r_state != S_IDLE))
        else $error("accepted word left the engine idle");

endmodule

[sv/binary_trie_max_xor.sv]
// Top level of the binary trie maximum-xor block.
// Input stream s_axis: tuser carries the kind (insert, delete, query), tdata the
// value or query key. Output stream m_axis: one word per input word, tdata the
// maximum xor (zero unless a query succeeds), tuser the status (ok, empty set,
// absent value, node pool full).
// Words pass an input register and a two-entry queue, then the engine walks the
// trie one level per cycle through a node store with two registered read ports.
// Words are handled one at a time in the engine; the input side keeps taking
// words until the queue and the input register are full.
// Reset empties the set at once: nodes above the allocation pointer read as
// empty, so no clearing pass runs and the first word is taken right after reset.
// A stalled m_axis holds its word; the engine waits with the next result and
// the input register and queue absorb three more words before s_axis_tready drops.
module binary_trie_max_xor import bmx_pkg::*; #(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int NODE_POOL  = DEF_NODE_POOL
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [30:0] key_value, [31] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [30:0] max_xor, [31] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int QW = VALUE_BITS + 2;

    logic                  fr_valid;
    logic                  fr_ready;
    t_op                   fr_op;
    logic [VALUE_BITS-1:0] fr_value;
    logic                  q_valid;
    logic                  q_ready;
    logic [QW-1:0]         q_data;
    logic [KEY_W-1:0]      max_xor;
    t_status               status;

    // Decode and register the input word
    bmx_front #(
        .VALUE_BITS(VALUE_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_kind  (s_axis_tuser),
        .i_key   (s_axis_tdata[KEY_W-1:0]),
        .o_valid (fr_valid),
        .i_ready (fr_ready),
        .o_op    (fr_op),
        .o_value (fr_value)
    );

    // Queue decoded words for the engine
    bmx_fifo #(
        .WIDTH(QW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (fr_ready),
        .i_data  ({fr_op, fr_value}),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_data)
    );

    // Walk the trie and produce one result word per item
    bmx_engine #(
        .VALUE_BITS(VALUE_BITS),
        .NODE_POOL (NODE_POOL)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .o_ready   (q_ready),
        .i_op      (t_op'(q_data[QW-1 -: 2])),
        .i_value   (q_data[VALUE_BITS-1:0]),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_max_xor (max_xor),
        .o_status  (status)
    );

    assign m_axis_tdata = {1'b0, max_xor};
    assign m_axis_tuser = status;

endmodule

[tb/sv/binary_trie_max_xor_check.sv]
// Checker for the binary trie maximum-xor block: trie predictor and result compare.
module binary_trie_max_xor_check import bmx_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_tvalid,
    input  logic              i_in_tready,
    input  logic [31:0]       i_in_tdata,    // [30:0] key_value, [31] zero
    input  logic [1:0]        i_in_tuser,    // [1:0] kind
    input  logic              i_out_tvalid,
    input  logic              i_out_tready,
    input  logic [31:0]       i_out_tdata,   // [30:0] max_xor, [31] zero
    input  logic [1:0]        i_out_tuser,   // [1:0] status
    output int                o_failures,
    output int                o_pending
);

    localparam int POOL   = DEF_NODE_POOL;
    localparam int LEVELS = DEF_VALUE_BITS;
    localparam int unsigned ROOT = 1;

    typedef struct packed {
        logic [KEY_W-1:0] max_xor;
        t_status          status;
    } t_answer;

    // Shadow node store; node 0 means no child and is never written
    int unsigned          zero_link  [POOL];
    int unsigned          one_link   [POOL];
    bit [COUNT_W-1:0]     pass_count [POOL];
    int unsigned          last_node = ROOT;

    t_answer answers_due[$];
    int      failures = 0;

    assign o_failures = failures;

    // Add one copy of a value; refuse when the pool or the root count is exhausted
    function automatic t_status add_value(input logic [KEY_W-1:0] v);
        int unsigned node;
        int unsigned nxt;
        int unsigned missing;
        if (pass_count[ROOT] >= COUNT_MAX)
            return ST_FULL;
        node = ROOT;
        missing = 0;
        for (int k = LEVELS - 1; k >= 0; k--) begin
            nxt = v[k] ? one_link[node] : zero_link[node];
            if (nxt == 0)
                missing++;
            node = nxt;
        end
        if (last_node >= POOL - 1 || missing > POOL - 1 - last_node)
            return ST_FULL;
        node = ROOT;
        pass_count[node]++;
        for (int k = LEVELS - 1; k >= 0; k--) begin
            nxt = v[k] ? one_link[node] : zero_link[node];
            if (nxt == 0) begin
                last_node++;
                nxt = last_node;
                if (v[k])
                    one_link[node] = nxt;
                else
                    zero_link[node] = nxt;
            end
            node = nxt;
            pass_count[node]++;
        end
        return ST_OK;
    endfunction

    // Remove one copy of a value; a missing node or a dead count means absent
    function automatic t_status remove_value(input logic [KEY_W-1:0] v);
        int unsigned node;
        int unsigned nxt;
        if (pass_count[ROOT] == 0)
            return ST_ABSENT;
        node = ROOT;
        for (int k = LEVELS - 1; k >= 0; k--) begin
            nxt = v[k] ? one_link[node] : zero_link[node];
            if (nxt == 0 || pass_count[nxt] == 0)
                return ST_ABSENT;
            node = nxt;
        end
        node = ROOT;
        pass_count[node]--;
        for (int k = LEVELS - 1; k >= 0; k--) begin
            node = v[k] ? one_link[node] : zero_link[node];
            pass_count[node]--;
        end
        return ST_OK;
    endfunction

    // Walk toward the opposite bit wherever a live child holds it
    function automatic t_status best_xor(input logic [KEY_W-1:0] key,
                                         output logic [KEY_W-1:0] found);
        int unsigned node;
        int unsigned opp;
        found = '0;
        if (pass_count[ROOT] == 0)
            return ST_EMPTY;
        node = ROOT;
        for (int k = LEVELS - 1; k >= 0; k--) begin
            opp = key[k] ? zero_link[node] : one_link[node];
            if (opp != 0 && pass_count[opp] != 0) begin
                node = opp;
                found[k] = 1'b1;
            end else begin
                node = key[k] ? one_link[node] : zero_link[node];
            end
        end
        return ST_OK;
    endfunction

    // Predict on every accepted input word, compare every accepted output word
    always @(posedge i_clk) begin : track
        t_answer want;
        if (i_rst_n) begin
            if (i_in_tvalid && i_in_tready) begin
                want.max_xor = '0;
                case (i_in_tuser)
                    KIND_INSERT: want.status = add_value(i_in_tdata[KEY_W-1:0]);
                    KIND_DELETE: want.status = remove_value(i_in_tdata[KEY_W-1:0]);
                    KIND_QUERY:  want.status = best_xor(i_in_tdata[KEY_W-1:0],
                                                        want.max_xor);
                    default:     want.status = ST_OK;
                endcase
                answers_due.push_back(want);
            end
            if (i_out_tvalid && i_out_tready) begin
                if (answers_due.size() == 0) begin
                    $display("%0t: unexpected word, got max_xor %h status %0d",
                             $time, i_out_tdata, i_out_tuser);
                    failures++;
                end else begin
                    want = answers_due.pop_front();
                    if (i_out_tdata !== {1'b0, want.max_xor}) begin
                        $display("%0t: max_xor mismatch, expected %h, got %h",
                                 $time, {1'b0, want.max_xor}, i_out_tdata);
                        failures++;
                    end
                    if (i_out_tuser !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, i_out_tuser);
                        failures++;
                    end
                end
            end
        end
        o_pending <= answers_due.size();
    end

endmodule

[tb/sv/binary_trie_max_xor_test.sv]
// Testbench top for the binary trie maximum-xor block: stimulus, flow control, verdict.
module binary_trie_max_xor_test;
    import bmx_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 100;
    localparam int PHASE_WORDS  = 350;
    localparam int FILL_WORDS   = 250;
    localparam int TAIL_WORDS   = 130;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [31:0] s_axis_tdata  = '0;    // [30:0] key_value, [31] zero
    logic [1:0]  s_axis_tuser  = '0;    // [1:0] kind
    logic        m_axis_tready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [31:0] m_axis_tdata;          // [30:0] max_xor, [31] zero
    logic [1:0]  m_axis_tuser;          // [1:0] status

    int send_idle_pct  = 0;
    int take_stall_pct = 0;
    int failures;
    int pending;
    int cycle_count    = 0;

    // Stimulus-side picture of the set, used only to steer toward live values
    logic [KEY_W-1:0] live_values[$];
    logic [KEY_W-1:0] gone_values[$];

    binary_trie_max_xor i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    binary_trie_max_xor_check u_watch (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tvalid  (s_axis_tvalid),
        .i_in_tready  (s_axis_tready),
        .i_in_tdata   (s_axis_tdata),
        .i_in_tuser   (s_axis_tuser),
        .i_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .i_out_tdata  (m_axis_tdata),
        .i_out_tuser  (m_axis_tuser),
        .o_failures   (failures),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Drop ready at random on the output side
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= take_stall_pct);
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("binary_trie_max_xor_test: FAIL");
            $finish;
        end
    end

    // Offer one word, idling first at random; return at the accepting edge
    task automatic send_word(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {1'b0, value};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    // Favor stored values, their near neighbors and removed ones over noise
    function automatic logic [KEY_W-1:0] likely_value();
        int pick;
        pick = $urandom_range(99);
        if (pick < 35 && live_values.size() != 0)
            return live_values[$urandom_range(live_values.size() - 1)];
        if (pick < 60 && live_values.size() != 0)
            return live_values[$urandom_range(live_values.size() - 1)]
                   ^ KEY_W'($urandom_range(255));
        if (pick < 75 && gone_values.size() != 0)
            return gone_values[$urandom_range(gone_values.size() - 1)];
        return KEY_W'($urandom);
    endfunction

    // One random word; insert odds shrink once the set grows
    task automatic random_word();
        int r;
        int ins_pct;
        int idx;
        logic [KEY_W-1:0] v;
        r = $urandom_range(99);
        ins_pct = (live_values.size() == 0) ? 55 : (live_values.size() > 48 ? 25 : 45);
        if (r < ins_pct) begin
            v = likely_value();
            send_word(KIND_INSERT, v);
            live_values.push_back(v);
        end else if (r < 65) begin
            if (live_values.size() != 0 && $urandom_range(9) < 8) begin
                idx = $urandom_range(live_values.size() - 1);
                v = live_values[idx];
                live_values.delete(idx);
                gone_values.push_back(v);
                if (gone_values.size() > 64)
                    void'(gone_values.pop_front());
            end else begin
                v = likely_value();
            end
            send_word(KIND_DELETE, v);
        end else if (r < 97) begin
            v = $urandom_range(1) ? KEY_W'($urandom) : likely_value();
            v = $urandom_range(1) ? likely_value() : v;
            send_word(KIND_QUERY, v);
        end else begin
            send_word(KIND_UNUSED, KEY_W'($urandom));
        end
    endtask

    initial begin : stimulus
        int idle_plan [4];
        int stall_plan[4];
        logic [KEY_W-1:0] spread;
        idle_plan  = '{0, 50, 0, 30};
        stall_plan = '{0, 0, 50, 30};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty set, extremes, duplicates, dead paths and the unused kind
        send_word(KIND_QUERY,  31'h0000_0000);
        send_word(KIND_DELETE, 31'h7FFF_FFFF);
        send_word(KIND_UNUSED, 31'h5555_5555);
        send_word(KIND_INSERT, 31'h0000_0000);
        send_word(KIND_QUERY,  31'h0000_0000);
        send_word(KIND_QUERY,  31'h7FFF_FFFF);
        send_word(KIND_INSERT, 31'h7FFF_FFFF);
        send_word(KIND_QUERY,  31'h0000_0000);
        send_word(KIND_QUERY,  31'h7FFF_FFFF);
        send_word(KIND_DELETE, 31'h4000_0000);
        send_word(KIND_DELETE, 31'h0000_0000);
        send_word(KIND_DELETE, 31'h0000_0000);
        send_word(KIND_QUERY,  31'h7FFF_FFFF);
        send_word(KIND_INSERT, 31'h7FFF_FFFF);
        send_word(KIND_DELETE, 31'h7FFF_FFFF);
        send_word(KIND_QUERY,  31'h2AAA_AAAA);
        send_word(KIND_DELETE, 31'h7FFF_FFFF);
        send_word(KIND_QUERY,  31'h1234_5678);
        send_word(KIND_INSERT, 31'h2AAA_AAAA);
        send_word(KIND_INSERT, 31'h5555_5555);
        send_word(KIND_QUERY,  31'h0000_0000);
        send_word(KIND_QUERY,  31'h7FFF_FFFF);
        send_word(KIND_UNUSED, 31'h7FFF_FFFF);
        live_values.push_back(31'h2AAA_AAAA);
        live_values.push_back(31'h5555_5555);

        // Random traffic under each flow-control mix
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_plan[p];
            take_stall_pct = stall_plan[p];
            repeat (PHASE_WORDS) random_word();
        end

        // Grow a wide trie with bit-reversed counters, which spread widest
        send_idle_pct  = 0;
        take_stall_pct = 0;
        for (int n = 0; n < FILL_WORDS; n++) begin
            for (int b = 0; b < KEY_W; b++)
                spread[b] = n[KEY_W-1-b];
            send_word(KIND_INSERT, spread);
        end

        // Keep working on the grown trie: queries across it, reinserts over dead paths
        send_idle_pct  = 30;
        take_stall_pct = 30;
        repeat (TAIL_WORDS) random_word();

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0)
            $display("binary_trie_max_xor_test: PASS");
        else
            $display("binary_trie_max_xor_test: FAIL");
        $finish;
    end

endmodule

[filelist.f]
sv/bmx_pkg.sv
sv/bmx_front.sv
sv/bmx_fifo.sv
sv/bmx_engine.sv
sv/binary_trie_max_xor.sv
tb/sv/binary_trie_max_xor_check.sv
tb/sv/binary_trie_max_xor_test.sv
